@@ sv/trq_pkg.sv @@
// trq_pkg: sizes, op codes, sequencer states and edge compare types
// shared by the threshold reachability block, trq_edge_cmp and the testbench
// no dependencies
package trq_pkg;

   localparam int MAX_NODES   = 256;
   localparam int MAX_EDGES   = 1024;
   localparam int WEIGHT_BITS = 16;

   localparam int NODE_BITS  = 8;
   localparam int NODE_AW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int TOP_W      = $clog2(MAX_NODES + 1);
   localparam int EDGE_AW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EDGE_CNT_W = $clog2(MAX_EDGES + 1);
   localparam int EDGE_W     = 2 * NODE_BITS + WEIGHT_BITS;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   typedef logic [NODE_BITS-1:0]   node_type;
   typedef logic [WEIGHT_BITS-1:0] weight_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_START,
      ST_POP,
      ST_POP_WAIT,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_VISIT_CHK,
      ST_FINAL
   } state_type;

   // outcome of comparing one stored edge against the current node
   typedef struct packed {
      logic     hit;
      node_type node;
   } edge_hit_type;

   function automatic logic node_ok(input node_type n, input node_type count);
      return (int'(n) < MAX_NODES) && (n <= count);
   endfunction

endpackage

@@ sv/threshold_reachability_query.sv @@
// threshold_reachability_query: top level, sequencer and the three rams
// depends on trq_pkg, trq_ram, trq_edge_cmp
//
//   channel  ports                                   role
//   req      req_valid/req_ready, op,a,b,value       one item in (clear, add, query)
//   rsp      rsp_valid/rsp_ready, reachable,overflow one item out for add and query
//   csr      csr_wr_en, csr_wr_data                  node_count write, no wait
//
// an add answers in the output register
// a query first runs a sweep that clears the visited ram, then each popped node goes
// through the pop, the read wait and the end-of-scan check, and scans all stored edges
// through the single edge ram port, with an extra visited check for each matching edge
// req_ready is low while a query runs and while a result waits on rsp
// synchronous active high reset clears control state; ram contents are not reset
module threshold_reachability_query (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  logic [7:0]          req_node_a,
   input  logic [7:0]          req_node_b,
   input  logic [15:0]         req_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_reachable,
   output logic                rsp_overflow,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data
);

   // sequencer state
   trq_pkg::state_type state_ff, state_in;

   // config and graph bookkeeping
   trq_pkg::node_type                  node_count_ff, node_count_in;
   logic [trq_pkg::EDGE_CNT_W-1:0]     edge_total_ff, edge_total_in;

   // walk registers
   trq_pkg::node_type                  start_ff, start_in;
   trq_pkg::node_type                  target_ff, target_in;
   trq_pkg::weight_type                width_ff, width_in;
   trq_pkg::node_type                  cur_ff, cur_in;
   trq_pkg::node_type                  cand_ff, cand_in;
   logic [trq_pkg::EDGE_CNT_W-1:0]     edge_idx_ff, edge_idx_in;
   logic [trq_pkg::TOP_W-1:0]          stack_top_ff, stack_top_in;
   logic [trq_pkg::NODE_AW-1:0]        clear_idx_ff, clear_idx_in;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_reachable_ff, rsp_reachable_in;
   logic rsp_overflow_ff, rsp_overflow_in;

   // ram ports
   logic                           edge_wr_en, edge_rd_en;
   logic [trq_pkg::EDGE_AW-1:0]    edge_wr_addr, edge_rd_addr;
   logic [trq_pkg::EDGE_W-1:0]     edge_wr_data, edge_rd_data;
   logic                           visit_wr_en, visit_rd_en;
   logic [trq_pkg::NODE_AW-1:0]    visit_wr_addr, visit_rd_addr;
   logic [0:0]                     visit_wr_data, visit_rd_data;
   logic                           stack_wr_en, stack_rd_en;
   logic [trq_pkg::NODE_AW-1:0]    stack_wr_addr, stack_rd_addr;
   trq_pkg::node_type              stack_wr_data, stack_rd_data;

   // misc
   trq_pkg::edge_hit_type          cmp_out;
   logic                           req_accept;
   logic                           query_ok;
   logic                           table_full;
   logic                           stack_empty;
   logic                           scan_done;
   logic [trq_pkg::TOP_W-1:0]      top_dec;

   assign req_ready     = (state_ff == trq_pkg::ST_IDLE) && !rsp_valid_ff;
   assign req_accept    = req_valid && req_ready;
   assign query_ok      = trq_pkg::node_ok(req_node_a, node_count_ff)
                          && trq_pkg::node_ok(req_node_b, node_count_ff);
   assign table_full    = (edge_total_ff >= trq_pkg::EDGE_CNT_W'(trq_pkg::MAX_EDGES));
   assign stack_empty   = (stack_top_ff == '0);
   assign scan_done     = (edge_idx_ff >= edge_total_ff);
   assign top_dec       = stack_top_ff - trq_pkg::TOP_W'(1);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_reachable = rsp_reachable_ff;
   assign rsp_overflow  = rsp_overflow_ff;

   // edge store: {weight, node_b, node_a} per entry
   trq_ram #(
      .WIDTH  (trq_pkg::EDGE_W),
      .DEPTH  (trq_pkg::MAX_EDGES),
      .ADDR_W (trq_pkg::EDGE_AW)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr_en),
      .wr_addr (edge_wr_addr),
      .wr_data (edge_wr_data),
      .rd_en   (edge_rd_en),
      .rd_addr (edge_rd_addr),
      .rd_data (edge_rd_data)
   );

   // visited map, cleared by a sweep at the start of each query
   trq_ram #(
      .WIDTH  (1),
      .DEPTH  (trq_pkg::MAX_NODES),
      .ADDR_W (trq_pkg::NODE_AW)
   ) u_visit_ram (
      .clock   (clock),
      .wr_en   (visit_wr_en),
      .wr_addr (visit_wr_addr),
      .wr_data (visit_wr_data),
      .rd_en   (visit_rd_en),
      .rd_addr (visit_rd_addr),
      .rd_data (visit_rd_data)
   );

   // depth-first walk stack
   trq_ram #(
      .WIDTH  (trq_pkg::NODE_BITS),
      .DEPTH  (trq_pkg::MAX_NODES),
      .ADDR_W (trq_pkg::NODE_AW)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_wr_en),
      .wr_addr (stack_wr_addr),
      .wr_data (stack_wr_data),
      .rd_en   (stack_rd_en),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_rd_data)
   );

   // the one compare unit, reused for every edge of every popped node
   trq_edge_cmp u_edge_cmp (
      .edge_word  (edge_rd_data),
      .cur_node   (cur_ff),
      .min_width  (width_ff),
      .node_count (node_count_ff),
      .result     (cmp_out)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         trq_pkg::ST_IDLE: begin
            if (req_accept && (req_op == trq_pkg::OP_QUERY) && query_ok) begin
               state_in = trq_pkg::ST_CLEAR;
            end
         end
         trq_pkg::ST_CLEAR: begin
            if (clear_idx_ff == trq_pkg::NODE_AW'(trq_pkg::MAX_NODES - 1)) begin
               state_in = trq_pkg::ST_START;
            end
         end
         trq_pkg::ST_START: begin
            state_in = trq_pkg::ST_POP;
         end
         trq_pkg::ST_POP: begin
            // empty stack: the walk is over, read the target's mark
            state_in = stack_empty ? trq_pkg::ST_FINAL : trq_pkg::ST_POP_WAIT;
         end
         trq_pkg::ST_POP_WAIT: begin
            state_in = trq_pkg::ST_SCAN_RD;
         end
         trq_pkg::ST_SCAN_RD: begin
            state_in = scan_done ? trq_pkg::ST_POP : trq_pkg::ST_SCAN_CMP;
         end
         trq_pkg::ST_SCAN_CMP: begin
            state_in = cmp_out.hit ? trq_pkg::ST_VISIT_CHK : trq_pkg::ST_SCAN_RD;
         end
         trq_pkg::ST_VISIT_CHK: begin
            state_in = trq_pkg::ST_SCAN_RD;
         end
         trq_pkg::ST_FINAL: begin
            state_in = trq_pkg::ST_IDLE;
         end
         default: begin
            state_in = trq_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath, ram controls and output register
   always_comb begin
      node_count_in    = csr_wr_en ? csr_wr_data : node_count_ff;
      edge_total_in    = edge_total_ff;
      start_in         = start_ff;
      target_in        = target_ff;
      width_in         = width_ff;
      cur_in           = cur_ff;
      cand_in          = cand_ff;
      edge_idx_in      = edge_idx_ff;
      stack_top_in     = stack_top_ff;
      clear_idx_in     = clear_idx_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_reachable_in = rsp_reachable_ff;
      rsp_overflow_in  = rsp_overflow_ff;

      edge_wr_en    = 1'b0;
      edge_wr_addr  = edge_total_ff[trq_pkg::EDGE_AW-1:0];
      edge_wr_data  = {trq_pkg::WEIGHT_BITS'(req_value), req_node_b, req_node_a};
      edge_rd_en    = 1'b0;
      edge_rd_addr  = edge_idx_ff[trq_pkg::EDGE_AW-1:0];
      visit_wr_en   = 1'b0;
      visit_wr_addr = clear_idx_ff;
      visit_wr_data = 1'b0;
      visit_rd_en   = 1'b0;
      visit_rd_addr = trq_pkg::NODE_AW'(cmp_out.node);
      stack_wr_en   = 1'b0;
      stack_wr_addr = stack_top_ff[trq_pkg::NODE_AW-1:0];
      stack_wr_data = cand_ff;
      stack_rd_en   = 1'b0;
      stack_rd_addr = top_dec[trq_pkg::NODE_AW-1:0];

      unique case (state_ff)
         trq_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_op)
                  trq_pkg::OP_CLEAR: begin
                     edge_total_in = '0;
                  end
                  trq_pkg::OP_ADD: begin
                     // a full table drops the edge and flags it
                     if (!table_full) begin
                        edge_wr_en    = 1'b1;
                        edge_total_in = edge_total_ff + trq_pkg::EDGE_CNT_W'(1);
                     end
                     rsp_valid_in     = 1'b1;
                     rsp_reachable_in = 1'b0;
                     rsp_overflow_in  = table_full;
                  end
                  trq_pkg::OP_QUERY: begin
                     if (query_ok) begin
                        start_in     = req_node_a;
                        target_in    = req_node_b;
                        width_in     = trq_pkg::WEIGHT_BITS'(req_value);
                        clear_idx_in = '0;
                     end else begin
                        // start or target out of range: unreachable
                        rsp_valid_in     = 1'b1;
                        rsp_reachable_in = 1'b0;
                        rsp_overflow_in  = 1'b0;
                     end
                  end
                  default: begin
                     // unused op: no effect, no result
                  end
               endcase
            end
         end
         trq_pkg::ST_CLEAR: begin
            visit_wr_en   = 1'b1;
            visit_wr_addr = clear_idx_ff;
            visit_wr_data = 1'b0;
            clear_idx_in  = clear_idx_ff + trq_pkg::NODE_AW'(1);
         end
         trq_pkg::ST_START: begin
            // mark and push the start node
            visit_wr_en   = 1'b1;
            visit_wr_addr = trq_pkg::NODE_AW'(start_ff);
            visit_wr_data = 1'b1;
            stack_wr_en   = 1'b1;
            stack_wr_addr = '0;
            stack_wr_data = start_ff;
            stack_top_in  = trq_pkg::TOP_W'(1);
         end
         trq_pkg::ST_POP: begin
            if (stack_empty) begin
               visit_rd_en   = 1'b1;
               visit_rd_addr = trq_pkg::NODE_AW'(target_ff);
            end else begin
               stack_rd_en  = 1'b1;
               stack_top_in = top_dec;
            end
         end
         trq_pkg::ST_POP_WAIT: begin
            cur_in      = stack_rd_data;
            edge_idx_in = '0;
         end
         trq_pkg::ST_SCAN_RD: begin
            if (!scan_done) begin
               edge_rd_en = 1'b1;
            end
         end
         trq_pkg::ST_SCAN_CMP: begin
            if (cmp_out.hit) begin
               visit_rd_en = 1'b1;
               cand_in     = cmp_out.node;
            end else begin
               edge_idx_in = edge_idx_ff + trq_pkg::EDGE_CNT_W'(1);
            end
         end
         trq_pkg::ST_VISIT_CHK: begin
            // push a node not seen before while the stack has room
            if (!visit_rd_data[0]
                && (stack_top_ff < trq_pkg::TOP_W'(trq_pkg::MAX_NODES))) begin
               visit_wr_en   = 1'b1;
               visit_wr_addr = trq_pkg::NODE_AW'(cand_ff);
               visit_wr_data = 1'b1;
               stack_wr_en   = 1'b1;
               stack_top_in  = stack_top_ff + trq_pkg::TOP_W'(1);
            end
            edge_idx_in = edge_idx_ff + trq_pkg::EDGE_CNT_W'(1);
         end
         trq_pkg::ST_FINAL: begin
            rsp_valid_in     = 1'b1;
            rsp_reachable_in = visit_rd_data[0];
            rsp_overflow_in  = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= trq_pkg::ST_IDLE;
         node_count_ff <= trq_pkg::NODE_BITS'(255);
         edge_total_ff <= '0;
         stack_top_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         edge_total_ff <= edge_total_in;
         stack_top_ff  <= stack_top_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      start_ff         <= start_in;
      target_ff        <= target_in;
      width_ff         <= width_in;
      cur_ff           <= cur_in;
      cand_ff          <= cand_in;
      edge_idx_ff      <= edge_idx_in;
      clear_idx_ff     <= clear_idx_in;
      rsp_reachable_ff <= rsp_reachable_in;
      rsp_overflow_ff  <= rsp_overflow_in;
   end

`ifndef SYNTHESIS
   a_no_accept_while_rsp_waits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready)
      else $error("item accepted while a result waits");

   a_query_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_op == trq_pkg::OP_QUERY) && query_ok)
      |=> (state_ff == trq_pkg::ST_CLEAR))
      else $error("in-range query did not start the visited sweep");

   a_final_gives_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == trq_pkg::ST_FINAL) |=> rsp_valid_ff)
      else $error("finished walk gave no result");

   a_stack_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != trq_pkg::ST_IDLE) |-> (stack_top_ff <= trq_pkg::TOP_W'(trq_pkg::MAX_NODES)))
      else $error("walk stack overran");

   a_edge_total_bounded: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_op == trq_pkg::OP_ADD) && table_full)
      |=> (edge_total_ff == $past(edge_total_ff)) && rsp_overflow_ff)
      else $error("add into full table was not dropped and flagged");
`endif

endmodule

@@ sv/trq_ram.sv @@
// trq_ram: generic single write port, single read port ram
// read data registered; no dependencies
module trq_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/trq_edge_cmp.sv @@
// trq_edge_cmp: weight threshold and endpoint match for one stored edge
// depends on trq_pkg
module trq_edge_cmp (
   input  logic [trq_pkg::EDGE_W-1:0] edge_word,
   input  trq_pkg::node_type          cur_node,
   input  trq_pkg::weight_type        min_width,
   input  trq_pkg::node_type          node_count,
   output trq_pkg::edge_hit_type      result
);

   trq_pkg::node_type   end_lo;
   trq_pkg::node_type   end_hi;
   trq_pkg::weight_type weight;
   logic                wide_enough;

   assign end_lo      = edge_word[trq_pkg::NODE_BITS-1:0];
   assign end_hi      = edge_word[2*trq_pkg::NODE_BITS-1:trq_pkg::NODE_BITS];
   assign weight      = edge_word[trq_pkg::EDGE_W-1:2*trq_pkg::NODE_BITS];
   assign wide_enough = (weight >= min_width);

   // low end matching takes precedence over high end
   always_comb begin
      result.hit  = 1'b0;
      result.node = end_lo;
      priority if (end_lo == cur_node) begin
         result.node = end_hi;
         result.hit  = wide_enough && trq_pkg::node_ok(end_hi, node_count);
      end else if (end_hi == cur_node) begin
         result.node = end_lo;
         result.hit  = wide_enough && trq_pkg::node_ok(end_lo, node_count);
      end else begin
         // edge does not touch the current node
         result.hit  = 1'b0;
      end
   end

endmodule

@@ sim/threshold_reachability_query_tb.sv @@
// testbench for threshold_reachability_query: directed and random edge/query traffic
// checked against an in-bench depth-first walk over a shadow edge table
// depends on trq_pkg and the threshold_reachability_query rtl
`timescale 1ns / 1ps

module threshold_reachability_query_tb;

   // op code with no meaning, the block must drop it silently
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // quiet time before a csr write or the verdict, covers a full visited sweep
   localparam int SETTLE_CYCLES = trq_pkg::MAX_NODES + 16;
   // far above the slowest legal run of this stimulus
   localparam int CYCLE_LIMIT = 20_000_000;
   // random items per node_count phase
   localparam int PHASE_ITEMS = 92;

   typedef struct packed {
      logic reachable;
      logic overflow;
   } answer_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_op = trq_pkg::OP_CLEAR;
   trq_pkg::node_type   req_node_a = '0;
   trq_pkg::node_type   req_node_b = '0;
   trq_pkg::weight_type req_value = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_reachable;
   logic                rsp_overflow;
   logic                csr_wr_en = 1'b0;
   logic [7:0]          csr_wr_data = '0;

   // shadow of the block: edge table and node_count register
   trq_pkg::node_type   link_lo [trq_pkg::MAX_EDGES];
   trq_pkg::node_type   link_hi [trq_pkg::MAX_EDGES];
   trq_pkg::weight_type link_weight [trq_pkg::MAX_EDGES];
   int                  link_count = 0;
   trq_pkg::node_type   node_limit = 8'd255;

   // answers owed by the block, oldest first
   answer_type answers_due [$];

   int cycle_count = 0;
   int fault_count = 0;

   // traffic shaping knobs
   logic idle_on = 1'b0;
   logic stall_on = 1'b0;
   int   burst_left = 0;
   int   stall_left = 0;
   logic stall_level = 1'b1;

   // node window for the random graphs, keeps most walks inside one cluster
   int hot_base = 0;
   int hot_span = 0;
   int traffic_items = 0;

   threshold_reachability_query u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_node_a    (req_node_a),
      .req_node_b    (req_node_b),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_reachable (rsp_reachable),
      .rsp_overflow  (rsp_overflow),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always #5 clock = ~clock;

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: always ready unless stall_on, then ready in runs of random length alternating with stall runs
   always @(posedge clock) begin
      if (!stall_on) begin
         rsp_ready <= 1'b1;
      end else begin
         if (stall_left == 0) begin
            stall_level = ~stall_level;
            stall_left = stall_level ? $urandom_range(1, 5) : $urandom_range(1, 16);
         end
         stall_left = stall_left - 1;
         rsp_ready <= stall_level;
      end
   end

   // result checker, every taken item against the oldest owed answer
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (answers_due.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("cycle %0d: result item with nothing owed (reachable %b overflow %b)",
                        cycle_count, rsp_reachable, rsp_overflow);
         end else begin
            want = answers_due.pop_front();
            if (rsp_reachable !== want.reachable || rsp_overflow !== want.overflow) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("cycle %0d: got reachable %b overflow %b, expected %b %b",
                           cycle_count, rsp_reachable, rsp_overflow,
                           want.reachable, want.overflow);
            end
         end
      end
   end

   function automatic logic in_range(input trq_pkg::node_type n);
      return n <= node_limit;
   endfunction

   // depth-first walk over the shadow table with an explicit node stack
   function automatic logic reach_from(input trq_pkg::node_type start,
                                       input trq_pkg::node_type target,
                                       input trq_pkg::weight_type width);
      logic              seen [trq_pkg::MAX_NODES];
      trq_pkg::node_type stack [trq_pkg::MAX_NODES];
      int                depth;
      trq_pkg::node_type cur;
      trq_pkg::node_type nxt;
      logic              hit;
      if (!in_range(start) || !in_range(target))
         return 1'b0;
      foreach (seen[i])
         seen[i] = 1'b0;
      seen[start] = 1'b1;
      stack[0] = start;
      depth = 1;
      while (depth > 0) begin
         depth--;
         cur = stack[depth];
         for (int e = 0; e < link_count; e++) begin
            hit = 1'b0;
            if (link_weight[e] >= width) begin
               if (link_lo[e] == cur) begin
                  nxt = link_hi[e];
                  hit = 1'b1;
               end else if (link_hi[e] == cur) begin
                  nxt = link_lo[e];
                  hit = 1'b1;
               end
            end
            if (hit && in_range(nxt) && !seen[nxt]) begin
               seen[nxt] = 1'b1;
               stack[depth] = nxt;
               depth++;
            end
         end
      end
      return seen[target];
   endfunction

   // update the shadow for one accepted item and note the answer it owes
   task automatic record_item(input logic [1:0] op, input trq_pkg::node_type a,
                              input trq_pkg::node_type b, input trq_pkg::weight_type v);
      answer_type ans;
      ans = '{reachable: 1'b0, overflow: 1'b0};
      case (op)
         trq_pkg::OP_CLEAR: begin
            link_count = 0;
         end
         trq_pkg::OP_ADD: begin
            if (link_count < trq_pkg::MAX_EDGES) begin
               link_lo[link_count] = a;
               link_hi[link_count] = b;
               link_weight[link_count] = v;
               link_count++;
            end else begin
               ans.overflow = 1'b1;
            end
            answers_due.push_back(ans);
         end
         trq_pkg::OP_QUERY: begin
            ans.reachable = reach_from(a, b, v);
            answers_due.push_back(ans);
         end
         default: begin
         end
      endcase
   endtask

   // sender: one item; with idle_on, bursts of random length with random gaps between them
   task automatic send_item(input logic [1:0] op, input trq_pkg::node_type a,
                            input trq_pkg::node_type b, input trq_pkg::weight_type v);
      int gap;
      if (idle_on && burst_left == 0) begin
         gap = $urandom_range(1, 9);
         burst_left = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0)
         burst_left--;
      req_valid  <= 1'b1;
      req_op     <= op;
      req_node_a <= a;
      req_node_b <= b;
      req_value  <= v;
      @(posedge clock);
      while (req_ready !== 1'b1)
         @(posedge clock);
      record_item(op, a, b, v);
   endtask

   // stop sending, collect every owed answer, then let the block settle
   task automatic drain_answers();
      req_valid <= 1'b0;
      while (answers_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr write, only with the block idle
   task automatic set_node_limit(input logic [7:0] limit);
      drain_answers();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      node_limit = limit;
   endtask

   function automatic trq_pkg::node_type pick_node();
      if ($urandom_range(0, 9) == 0)
         return trq_pkg::node_type'($urandom_range(0, 255));
      return trq_pkg::node_type'(hot_base + $urandom_range(0, hot_span));
   endfunction

   function automatic trq_pkg::weight_type pick_weight();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return trq_pkg::weight_type'($urandom_range(0, 65535));
      endcase
   endfunction

   // unused op now and then, full random fields
   task automatic maybe_noise();
      if ($urandom_range(0, 11) == 0)
         send_item(OP_UNUSED, trq_pkg::node_type'($urandom_range(0, 255)),
                   trq_pkg::node_type'($urandom_range(0, 255)),
                   trq_pkg::weight_type'($urandom_range(0, 65535)));
   endtask

   // default node_count, empty graph, all ops, weight extremes, loops and parallel edges
   task automatic test_basic_ops();
      send_item(trq_pkg::OP_QUERY, 8'd255, 8'd255, '1);  // start is target at the top node
      send_item(trq_pkg::OP_QUERY, 8'd0, 8'd1, '0);      // nothing stored yet
      send_item(trq_pkg::OP_ADD, 8'd0, 8'd255, '1);
      send_item(trq_pkg::OP_ADD, 8'd255, 8'd7, '0);
      send_item(trq_pkg::OP_ADD, 8'd5, 8'd5, 16'd100);    // self loop
      send_item(trq_pkg::OP_ADD, 8'd1, 8'd2, 16'd10);
      send_item(trq_pkg::OP_ADD, 8'd2, 8'd1, 16'd20);     // parallel edge, reversed ends
      send_item(OP_UNUSED, 8'hff, 8'hff, '1);             // must be dropped
      send_item(trq_pkg::OP_QUERY, 8'd0, 8'd7, '0);
      send_item(trq_pkg::OP_QUERY, 8'd0, 8'd7, 16'd1);    // zero weight edge now too thin
      send_item(trq_pkg::OP_QUERY, 8'd7, 8'd0, '1);
      send_item(trq_pkg::OP_QUERY, 8'd0, 8'd255, '1);
      send_item(trq_pkg::OP_QUERY, 8'd1, 8'd2, 16'd20);
      send_item(trq_pkg::OP_QUERY, 8'd2, 8'd1, 16'd21);
      send_item(trq_pkg::OP_QUERY, 8'd5, 8'd5, '1);
      send_item(trq_pkg::OP_CLEAR, 8'haa, 8'h55, 16'h5a5a);
      send_item(trq_pkg::OP_QUERY, 8'd0, 8'd255, '0);    // table emptied
   endtask

   // nodes above node_count are stored but never walked through
   task automatic test_node_limits();
      set_node_limit(8'd7);
      send_item(trq_pkg::OP_CLEAR, '0, '0, '0);
      send_item(trq_pkg::OP_ADD, 8'd3, 8'd200, 16'd500);
      send_item(trq_pkg::OP_ADD, 8'd200, 8'd4, 16'd500);
      send_item(trq_pkg::OP_ADD, 8'd3, 8'd7, 16'd9);
      send_item(trq_pkg::OP_QUERY, 8'd3, 8'd4, '0);      // only bridge is out of range
      send_item(trq_pkg::OP_QUERY, 8'd3, 8'd200, '0);
      send_item(trq_pkg::OP_QUERY, 8'd200, 8'd3, '0);
      send_item(trq_pkg::OP_QUERY, 8'd7, 8'd3, 16'd9);
      send_item(trq_pkg::OP_QUERY, 8'd3, 8'd8, '0);      // just above the limit
      set_node_limit(8'd0);
      send_item(trq_pkg::OP_QUERY, 8'd0, 8'd0, '0);
      send_item(trq_pkg::OP_QUERY, 8'd0, 8'd1, '0);
      set_node_limit(8'd255);
   endtask

   // fill the edge table, push past it, then clear and reuse
   task automatic test_table_full();
      set_node_limit(8'd3);
      idle_on = 1'b1;
      stall_on = 1'b1;
      send_item(trq_pkg::OP_CLEAR, '0, '0, '0);
      repeat (trq_pkg::MAX_EDGES)
         send_item(trq_pkg::OP_ADD, trq_pkg::node_type'($urandom_range(0, 5)),
                   trq_pkg::node_type'($urandom_range(0, 5)), pick_weight());
      repeat (3)
         send_item(trq_pkg::OP_ADD, trq_pkg::node_type'($urandom_range(0, 255)),
                   trq_pkg::node_type'($urandom_range(0, 255)), pick_weight());
      send_item(trq_pkg::OP_QUERY, 8'd0, 8'd3, pick_weight());
      send_item(trq_pkg::OP_QUERY, 8'd1, 8'd2, '0);
      send_item(trq_pkg::OP_CLEAR, '1, '1, '1);
      send_item(trq_pkg::OP_ADD, 8'd1, 8'd2, 16'd1);
      send_item(trq_pkg::OP_QUERY, 8'd2, 8'd1, 16'd1);
   endtask

   // random graphs under several node_count settings
   task automatic test_random_traffic();
      int phase_limits [6];
      int limit;
      int n_links;
      int n_queries;
      phase_limits = '{15, 1, 31, 255, 7, -1};
      for (int p = 0; p < 6; p++) begin
         limit = (phase_limits[p] < 0) ? $urandom_range(1, 255) : phase_limits[p];
         set_node_limit(8'(limit));
         // first phase runs flat out on both sides
         idle_on = (p != 0) && ($urandom_range(0, 3) != 0);
         stall_on = (p != 0) && ($urandom_range(0, 3) != 0);
         traffic_items = 0;
         while (traffic_items < PHASE_ITEMS) begin
            // keep the table small so walks stay short
            if (link_count > 40 || $urandom_range(0, 3) == 0) begin
               send_item(trq_pkg::OP_CLEAR, trq_pkg::node_type'($urandom_range(0, 255)),
                         trq_pkg::node_type'($urandom_range(0, 255)),
                         trq_pkg::weight_type'($urandom_range(0, 65535)));
               traffic_items++;
            end
            hot_span = (limit < 12) ? limit : 12;
            hot_base = $urandom_range(0, limit - hot_span);
            n_links = $urandom_range(1, 20);
            n_queries = $urandom_range(1, 8);
            repeat (n_links) begin
               maybe_noise();
               send_item(trq_pkg::OP_ADD, pick_node(), pick_node(), pick_weight());
               traffic_items++;
            end
            repeat (n_queries) begin
               maybe_noise();
               send_item(trq_pkg::OP_QUERY, pick_node(), pick_node(), pick_weight());
               traffic_items++;
            end
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_ops();
      test_node_limits();
      test_table_full();
      test_random_traffic();
      drain_answers();
      if (fault_count == 0 && answers_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ threshold_reachability_query.f @@
sv/trq_pkg.sv
sv/trq_ram.sv
sv/trq_edge_cmp.sv
sv/threshold_reachability_query.sv
sim/threshold_reachability_query_tb.sv
